>>> rtl/gbr_pkg.sv
// gbr_pkg: shared types, constants and helpers of the go-back-n frame receiver
// used by gbr_front, gbr_cmd_fifo, gbr_back and goback_n_frame_receiver_core
// no dependencies
`default_nettype none

package gbr_pkg;

    localparam int PAYLOAD_BYTES_DEF     = 21;
    localparam int FRAMES_PER_PACKET_DEF = 7;
    localparam int QUEUE_DEPTH           = 2;

    localparam int HDR_BYTES = 6;
    localparam int SEQ_W     = 3;
    localparam int CNT_W     = 6;
    localparam int ADDR_W    = 5;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] TYPE_ACK  = 8'h00;

    typedef enum logic [1:0] {
        KIND_ACK_RX  = 2'd0,
        KIND_ACK_TX  = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ACK  = 3'b010,
        ST_PAY  = 3'b100
    } back_state_t;

    // judged frame handed from front to back
    typedef struct packed {
        logic             is_ack;
        logic [7:0]       seq;
        logic [7:0]       src;
        logic [7:0]       station;
        logic [7:0]       ack_sum;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       off_base;
        logic             done;
    } cmd_t;

    // payload store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } pw_t;

    function automatic logic [4:0] nib2(input logic [7:0] b);
        return 5'(b[3:0]) + 5'(b[7:4]);
    endfunction

endpackage

`default_nettype wire

>>> rtl/gbr_front.sv
// gbr_front: byte parser, header capture, checksum and frame judgement
// depends on gbr_pkg; pushes judged frames to gbr_cmd_fifo, writes payload into gbr_back
`default_nettype none

module gbr_front
    import gbr_pkg::*;
#(
    parameter int PAYLOAD_BYTES     = PAYLOAD_BYTES_DEF,
    parameter int FRAMES_PER_PACKET = FRAMES_PER_PACKET_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       station_id_we,
    input  wire logic [7:0] station_id_wdata,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       lock,
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            cmd,
    output pw_t             pw
);

    localparam int POS_W   = $clog2(PAYLOAD_BYTES + 9);
    localparam int SUM_W   = $clog2(30 * (PAYLOAD_BYTES + 5) + 1);
    localparam int PAY_END = PAYLOAD_BYTES + HDR_BYTES;
    localparam int CK_HI   = PAYLOAD_BYTES + 7;
    localparam int FOOT    = PAYLOAD_BYTES + 8;

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             check_ok_reg, check_ok_next;
    logic [SEQ_W-1:0] last_reg, last_next;
    logic [7:0]       station_id_reg;
    logic [7:0]       hdr_reg [0:HDR_BYTES-1];
    logic [7:0]       cklo_reg;

    logic             accept;
    logic             eff_in;
    logic [POS_W-1:0] p;
    logic [SUM_W-1:0] sum_base;
    logic [15:0]      sum16;
    logic             in_sum_range;
    logic             footer;
    logic             frame_ok;
    logic             is_ack_type;
    logic             seq_match;
    logic             seq_final;

    assign s_tready = !(lock && in_frame_reg && pos_reg >= POS_W'(HDR_BYTES)
                        && pos_reg < POS_W'(PAY_END))
                   && !(q_full && in_frame_reg && pos_reg == POS_W'(FOOT));

    assign accept       = s_tvalid && s_tready;
    assign eff_in       = s_tuser || in_frame_reg;
    assign p            = s_tuser ? '0 : pos_reg;
    assign sum_base     = s_tuser ? '0 : sum_reg;
    assign sum16        = 16'(sum_reg);
    assign in_sum_range = (p >= POS_W'(1)) && (p < POS_W'(PAY_END));

    assign frame_ok    = (hdr_reg[0] == FLAG_BYTE) && (hdr_reg[4] == station_id_reg)
                      && check_ok_reg;
    assign is_ack_type = (hdr_reg[1] == TYPE_ACK);
    assign seq_match   = ((8'(last_reg) + 8'd1) == hdr_reg[2]);
    assign seq_final   = (hdr_reg[2] == 8'(FRAMES_PER_PACKET));
    assign footer      = accept && eff_in && (p == POS_W'(FOOT));
    assign push        = footer && frame_ok && (is_ack_type || seq_match);

    always_comb
    begin
        cmd.is_ack   = is_ack_type;
        cmd.seq      = hdr_reg[2];
        cmd.src      = hdr_reg[3];
        cmd.station  = station_id_reg;
        cmd.ack_sum  = 8'(nib2(hdr_reg[2])) + 8'(nib2(station_id_reg))
                     + 8'(nib2(hdr_reg[3])) + 8'(nib2(8'(PAYLOAD_BYTES)));
        cmd.cnt      = (hdr_reg[5] > 8'(PAYLOAD_BYTES)) ? CNT_W'(PAYLOAD_BYTES)
                                                        : hdr_reg[5][CNT_W-1:0];
        cmd.off_base = 8'(8'(PAYLOAD_BYTES) * 8'(last_reg));
        cmd.done     = seq_final;
    end

    always_comb
    begin
        pw.we   = accept && eff_in && (p >= POS_W'(HDR_BYTES)) && (p < POS_W'(PAY_END));
        pw.addr = ADDR_W'(p - POS_W'(HDR_BYTES));
        pw.data = s_tdata;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        check_ok_next = check_ok_reg;
        last_next     = last_reg;
        if (accept && eff_in)
        begin
            sum_next = in_sum_range ? sum_base + SUM_W'(nib2(s_tdata)) : sum_base;
            if (p == POS_W'(CK_HI))
            begin
                check_ok_next = (cklo_reg == sum16[7:0]) && (s_tdata == sum16[15:8]);
            end
            if (p == POS_W'(FOOT))
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
                if (push && !is_ack_type)
                begin
                    last_next = seq_final ? '0 : last_reg + SEQ_W'(1);
                end
            end
            else
            begin
                in_frame_next = 1'b1;
                pos_next      = p + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            pos_reg        <= '0;
            sum_reg        <= '0;
            check_ok_reg   <= 1'b0;
            last_reg       <= '0;
            station_id_reg <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            check_ok_reg <= check_ok_next;
            last_reg     <= last_next;
            if (station_id_we)
            begin
                station_id_reg <= station_id_wdata;
            end
        end
    end

    // header bytes and checksum low byte
    always_ff @(posedge clk)
    begin
        if (accept && eff_in && p < POS_W'(HDR_BYTES))
        begin
            hdr_reg[p[2:0]] <= s_tdata;
        end
        if (accept && eff_in && p == POS_W'(PAY_END))
        begin
            cklo_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gbr_cmd_fifo.sv
// gbr_cmd_fifo: short queue of judged frames between front and back
// depends on gbr_pkg (cmd_t, QUEUE_DEPTH)
`default_nettype none

module gbr_cmd_fifo
    import gbr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t cmd_in,
    input  wire logic pop,
    output cmd_t      cmd_out,
    output logic      empty,
    output logic      full
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          q_mem [0:QUEUE_DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign cmd_out = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gbr_back.sv
// gbr_back: result sequencer, payload store and output register
// depends on gbr_pkg; takes judged frames from gbr_cmd_fifo
`default_nettype none

module gbr_back
    import gbr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    input  wire pw_t         pw,
    output logic             busy,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam int POS_W = $clog2(PAYLOAD_BYTES + 9);
    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int FOOT  = PAYLOAD_BYTES + 8;

    logic [7:0]       store_mem [0:PAYLOAD_BYTES-1];

    back_state_t      state_reg, state_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic             out_valid_reg, out_valid_next;
    cmd_t             cmd_reg;
    kind_t            out_kind_reg;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_off_reg;
    logic             out_done_reg;
    logic             out_last_reg;

    logic             advance;
    logic             load;
    logic             pay_last;
    logic             ack_end;
    logic [7:0]       ack_byte;

    assign advance  = !out_valid_reg || m_tready;
    assign q_pop    = advance && (state_reg == ST_IDLE) && !q_empty;
    assign load     = q_pop || (advance && state_reg != ST_IDLE);
    assign pay_last = ((CNT_W'(i_reg) + CNT_W'(1)) == cmd_reg.cnt);
    assign ack_end  = (idx_reg == POS_W'(FOOT));
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        if (idx_reg == POS_W'(0) || idx_reg == POS_W'(FOOT))
        begin
            ack_byte = FLAG_BYTE;
        end
        else if (idx_reg == POS_W'(2))
        begin
            ack_byte = cmd_reg.seq;
        end
        else if (idx_reg == POS_W'(3))
        begin
            ack_byte = cmd_reg.station;
        end
        else if (idx_reg == POS_W'(4))
        begin
            ack_byte = cmd_reg.src;
        end
        else if (idx_reg == POS_W'(5))
        begin
            ack_byte = 8'(PAYLOAD_BYTES);
        end
        else if (idx_reg == POS_W'(PAYLOAD_BYTES + 6))
        begin
            ack_byte = cmd_reg.ack_sum;
        end
        else
        begin
            ack_byte = 8'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        i_next         = i_reg;
        out_valid_next = advance ? load : out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && !q_cmd.is_ack)
                begin
                    state_next = ST_ACK;
                    idx_next   = POS_W'(1);
                end
            end
            ST_ACK:
            begin
                if (advance)
                begin
                    if (ack_end)
                    begin
                        state_next = (cmd_reg.cnt == '0) ? ST_IDLE : ST_PAY;
                        i_next     = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + POS_W'(1);
                    end
                end
            end
            ST_PAY:
            begin
                if (advance)
                begin
                    if (pay_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw.we)
        begin
            store_mem[pw.addr[IDX_W-1:0]] <= pw.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (load)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    out_kind_reg <= q_cmd.is_ack ? KIND_ACK_RX : KIND_ACK_TX;
                    out_data_reg <= q_cmd.is_ack ? q_cmd.seq : FLAG_BYTE;
                    out_off_reg  <= 8'd0;
                    out_done_reg <= 1'b0;
                    out_last_reg <= q_cmd.is_ack;
                end
                ST_ACK:
                begin
                    out_kind_reg <= KIND_ACK_TX;
                    out_data_reg <= ack_byte;
                    out_off_reg  <= 8'd0;
                    out_done_reg <= 1'b0;
                    out_last_reg <= ack_end && (cmd_reg.cnt == '0);
                end
                ST_PAY:
                begin
                    out_kind_reg <= KIND_PAYLOAD;
                    out_data_reg <= store_mem[i_reg];
                    out_off_reg  <= cmd_reg.off_base + 8'(i_reg);
                    out_done_reg <= cmd_reg.done && pay_last;
                    out_last_reg <= pay_last;
                end
                default:
                begin
                    out_kind_reg <= KIND_ACK_TX;
                    out_data_reg <= 8'd0;
                    out_off_reg  <= 8'd0;
                    out_done_reg <= 1'b0;
                    out_last_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_done_reg, out_off_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/goback_n_frame_receiver_core.sv
// goback_n_frame_receiver_core: go-back-n frame receiver, top level
// depends on gbr_pkg, gbr_front, gbr_cmd_fifo, gbr_back
//
// usage
//  s_* takes one received byte per item; s_tuser high marks the first byte of
//  a frame and always restarts parsing. a frame is PAYLOAD_BYTES+9 bytes.
//  station_id_we/station_id_wdata set the station address; write it only
//  while the block is idle.
//  m_* gives result items; m_tuser is the kind (ack received, ack frame byte
//  to send, payload byte) and m_tlast closes the run caused by one footer.
// timing
//  bytes are taken one per cycle while a frame streams in. the footer pushes
//  a judged frame into a two-entry queue; the back pops it into its output
//  register and then gives one result per cycle while m_tready is high: one
//  ack received item for an ack frame, else PAYLOAD_BYTES+9 ack frame bytes
//  plus up to PAYLOAD_BYTES payload bytes, set by the back sequencer.
//  payload bytes of the next frame wait until the queue is empty and the back
//  sequencer is idle again; a footer waits while the queue is full.
// reset
//  rst_n clears parser, sequence, queue and output valid; station_id is 0.
//  when m_tready is low the output register holds and the back stalls.
`default_nettype none

module goback_n_frame_receiver_core
    import gbr_pkg::*;
#(
    parameter int PAYLOAD_BYTES     = PAYLOAD_BYTES_DEF,
    parameter int FRAMES_PER_PACKET = FRAMES_PER_PACKET_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        station_id_we,
    input  wire logic [7:0]  station_id_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // data_byte, payload_offset, packet_done
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast
);

    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    logic busy;
    logic lock;
    cmd_t cmd_in;
    cmd_t cmd_out;
    pw_t  pw;

    assign lock = busy || !q_empty;

    gbr_front #(
        .PAYLOAD_BYTES     (PAYLOAD_BYTES),
        .FRAMES_PER_PACKET (FRAMES_PER_PACKET)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .station_id_we    (station_id_we),
        .station_id_wdata (station_id_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .lock             (lock),
        .q_full           (q_full),
        .push             (push),
        .cmd              (cmd_in),
        .pw               (pw)
    );

    gbr_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_in),
        .pop     (pop),
        .cmd_out (cmd_out),
        .empty   (q_empty),
        .full    (q_full)
    );

    gbr_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (cmd_out),
        .q_pop    (pop),
        .pw       (pw),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_store_locked: assert property (@(posedge clk) disable iff (!rst_n)
        pw.we |-> !lock)
        else $error("payload store written while back still reads it");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("judged frame pushed into full queue");

    a_ack_rx_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_ACK_RX) |-> m_tlast)
        else $error("ack received item not alone in its run");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[16]) |-> (m_tlast && m_tuser == KIND_PAYLOAD))
        else $error("packet done on an item that does not close the run");

endmodule

`default_nettype wire
